/* rtl/core/dtss_pkg.sv */
// Shared types, constants and helpers of the drum trigger step sequencer.
package dtss_pkg;

    localparam int MV_W     = 15;
    localparam int STEPS_W  = 7;
    localparam int PICK_W   = 2;
    localparam int INDEX_W  = 8;
    localparam int VOICE_W  = 3;
    localparam int PTR_W    = 8;
    localparam int GATES    = 4;

    typedef logic signed [MV_W-1:0] t_mv;
    typedef logic [GATES-1:0]       t_gates;
    typedef logic [VOICE_W-1:0]     t_voice;
    typedef logic [PTR_W-1:0]       t_ptr;

    // operation field codes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam t_ptr ARMED_POINTER = 8'hFF;

    // level thresholds, mV
    localparam t_mv LVL_ZERO  = 15'sd0;
    localparam t_mv LVL_HIGH  = 15'sd2000;
    localparam t_mv VAR_1000  = 15'sd1000;
    localparam t_mv VAR_2000  = 15'sd2000;
    localparam t_mv VAR_3000  = 15'sd3000;
    localparam t_mv VAR_4000  = 15'sd4000;
    localparam t_mv VAR_5000  = 15'sd5000;
    localparam t_mv VAR_6000  = 15'sd6000;
    localparam t_mv VAR_7000  = 15'sd7000;

    // n / 100 for n <= 16384: (n * 5243) >> 19 is exact over that range
    localparam int           PROD_W       = 28;
    localparam int           DIV100_SHIFT = 19;
    localparam logic [12:0]  DIV100_RECIP = 13'd5243;

    // what the gate stage does with a beat
    typedef enum logic [1:0] {
        ACT_HOLD,
        ACT_SET,
        ACT_PAT
    } t_act;

    typedef struct packed {
        t_act   act;
        logic   mirror;
        t_gates vec;
    } t_s1_ctrl;

    // gate bit for a stored voice number; voices outside 1..4 raise nothing
    function automatic t_gates voice_gate(input t_voice voice, input logic mirror);
        t_gates g;
        g = '0;
        case (voice)
            3'd1:    g = mirror ? 4'b1000 : 4'b0001;
            3'd2:    g = mirror ? 4'b0100 : 4'b0010;
            3'd3:    g = mirror ? 4'b0010 : 4'b0100;
            3'd4:    g = mirror ? 4'b0001 : 4'b1000;
            default: g = '0;
        endcase
        return g;
    endfunction

    function automatic t_gates pick_gate(input logic [PICK_W-1:0] pick);
        return t_gates'(1) << pick;
    endfunction

endpackage

/* rtl/core/dtss_in_if.sv */
// Input channel of the sequencer: sample ticks and pattern writes.
interface dtss_in_if import dtss_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                operation;
    t_mv                 reset_mv;
    t_mv                 clock_mv;
    logic [STEPS_W-1:0]  step_count;
    t_mv                 variation_mv;
    logic [PICK_W-1:0]   random_pick;
    logic [INDEX_W-1:0]  pattern_index;
    logic [VOICE_W-1:0]  pattern_value;

    modport source (
        output valid, operation, reset_mv, clock_mv, step_count, variation_mv,
               random_pick, pattern_index, pattern_value,
        input  ready
    );
    modport sink (
        input  valid, operation, reset_mv, clock_mv, step_count, variation_mv,
               random_pick, pattern_index, pattern_value,
        output ready
    );
endinterface

/* rtl/core/dtss_out_if.sv */
// Output channel of the sequencer: the four gate levels.
interface dtss_out_if import dtss_pkg::*; ();
    logic valid;
    logic ready;
    logic kick_gate;
    logic snare_gate;
    logic closed_hat_gate;
    logic open_hat_gate;

    modport source (
        output valid, kick_gate, snare_gate, closed_hat_gate, open_hat_gate,
        input  ready
    );
    modport sink (
        input  valid, kick_gate, snare_gate, closed_hat_gate, open_hat_gate,
        output ready
    );
endinterface

/* rtl/core/drum_trigger_step_sequencer.sv */
// Top level of the four-voice drum trigger step sequencer.
//
//  channel    dir  payload                                          beats
//  i_sample   in   operation, levels, step_count, pick, write addr  one per item
//  o_gates    out  kick, snare, closed hat, open hat gates          one per item
//
// One beat in per cycle while i_sample.ready is high; each result passes the stage 1 registers
// (pointer update and pattern read), then the gate update into the output register.
// The pattern memory has one synchronous port: one read or one write per beat.
// After reset the pattern is cleared, with i_sample.ready low until every entry is zeroed.
// An output stall holds the gate stage; one more input beat is taken meanwhile.
module drum_trigger_step_sequencer import dtss_pkg::*; #(
    parameter int PATTERN_DEPTH = 256,
    parameter int MAX_STEPS     = 99
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dtss_in_if.sink     i_sample,
    dtss_out_if.source  o_gates
);

    localparam int AW = $clog2(PATTERN_DEPTH);
    localparam int BW = ((AW > PTR_W) ? AW : PTR_W) + 1;
    localparam logic [BW-1:0] DEPTH_M1  = BW'(PATTERN_DEPTH - 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(PATTERN_DEPTH - 1);
    localparam t_ptr          MAX_PTR   = PTR_W'(MAX_STEPS);

    t_voice r_mem [PATTERN_DEPTH];
    t_voice r_rdata;

    t_mv             r_prev_rst, r_prev_clk;
    t_ptr            r_ptr;
    t_gates          r_gate;
    logic            r_clearing;
    logic [AW-1:0]   r_clr_addr;
    logic            r_s1_vld;
    t_s1_ctrl        r_s1;
    logic            r_out_vld;
    t_gates          r_out_gate;

    logic            w_acc, w_s1_adv, w_tick, w_write;
    logic            w_rst_edge, w_clk_edge, w_clk_fall;
    t_ptr            w_steps, w_base, w_inc, w_pnext;
    logic [14:0]     w_neg;
    logic [PROD_W-1:0] w_prod;
    logic [BW-1:0]   w_off, w_bound, w_offc, w_sum, w_addr_raw;
    logic [AW-1:0]   w_mem_addr;
    t_s1_ctrl        n_s1;
    t_gates          n_gate;
    logic            w_mem_we;
    logic [AW-1:0]   w_mem_wa;
    t_voice          w_mem_wd;

    assign w_s1_adv       = r_s1_vld && (!r_out_vld || o_gates.ready);
    assign i_sample.ready = !r_clearing && (!r_s1_vld || w_s1_adv);
    assign w_acc          = i_sample.valid && i_sample.ready;
    assign w_write        = w_acc && (i_sample.operation == OP_WRITE);
    assign w_tick         = w_acc && (i_sample.operation == OP_TICK);

    // stage 1: edge detection, pointer, pattern address
    always_comb begin
        w_steps = (t_ptr'(i_sample.step_count) > MAX_PTR) ? MAX_PTR
                                                          : t_ptr'(i_sample.step_count);
        w_rst_edge = (r_prev_rst <= LVL_ZERO) && (i_sample.reset_mv > LVL_HIGH);
        w_clk_edge = (r_prev_clk <= LVL_ZERO) && (i_sample.clock_mv > LVL_HIGH);
        w_clk_fall = !w_clk_edge && (r_prev_clk > LVL_ZERO)
                     && (i_sample.clock_mv <= LVL_HIGH);
        w_base  = w_rst_edge ? ARMED_POINTER : r_ptr;
        w_inc   = w_base + t_ptr'(1);
        w_pnext = (w_inc >= w_steps) ? '0 : w_inc;

        w_neg   = 15'(-i_sample.variation_mv);
        w_prod  = PROD_W'(w_neg) * PROD_W'(DIV100_RECIP);
        w_off   = BW'(w_prod[PROD_W-1:DIV100_SHIFT]);
        w_bound = (BW'(w_steps) >= DEPTH_M1) ? '0 : DEPTH_M1 - BW'(w_steps);
        w_offc  = (w_off > w_bound) ? w_bound : w_off;
        w_sum   = BW'(w_pnext) + w_offc;

        if (w_write) begin
            w_addr_raw = BW'(i_sample.pattern_index);
        end else if (i_sample.variation_mv < LVL_ZERO) begin
            w_addr_raw = w_sum;
        end else begin
            w_addr_raw = BW'(w_pnext);
        end

        n_s1.act    = ACT_HOLD;
        n_s1.mirror = 1'b0;
        n_s1.vec    = '0;
        if (i_sample.operation == OP_TICK) begin
            if (w_clk_edge) begin
                n_s1.act = ACT_SET;
                if (w_steps == '0 || i_sample.variation_mv >= VAR_7000) begin
                    n_s1.vec = pick_gate(i_sample.random_pick);
                end else if (i_sample.variation_mv >= VAR_6000) begin
                    n_s1.act    = ACT_PAT;
                    n_s1.mirror = 1'b1;
                end else if (i_sample.variation_mv >= VAR_5000) begin
                    n_s1.vec = 4'b0000;
                end else if (i_sample.variation_mv >= VAR_4000) begin
                    n_s1.vec = 4'b1000;
                end else if (i_sample.variation_mv >= VAR_3000) begin
                    n_s1.vec = 4'b0100;
                end else if (i_sample.variation_mv >= VAR_2000) begin
                    n_s1.vec = 4'b0010;
                end else if (i_sample.variation_mv >= VAR_1000) begin
                    n_s1.vec = 4'b0001;
                end else begin
                    n_s1.act = ACT_PAT;
                end
            end else if (w_clk_fall) begin
                n_s1.act = ACT_SET;
            end
        end
    end

    // address wrap modulo the pattern depth
    generate
        if (PATTERN_DEPTH < 256) begin : g_wrap
            logic [AW-1:0] wrap_rom [256];
            for (genvar g = 0; g < 256; g++) begin : g_ent
                assign wrap_rom[g] = AW'(g % PATTERN_DEPTH);
            end
            assign w_mem_addr = wrap_rom[w_addr_raw[7:0]];
        end else begin : g_direct
            assign w_mem_addr = w_addr_raw[AW-1:0];
        end
    endgenerate

    assign w_mem_we = r_clearing || w_write;
    assign w_mem_wa = r_clearing ? r_clr_addr : w_mem_addr;
    assign w_mem_wd = r_clearing ? '0 : i_sample.pattern_value;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_wa] <= w_mem_wd;
        end
        if (w_tick) begin
            r_rdata <= r_mem[w_mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_rst <= '0;
            r_prev_clk <= '0;
            r_ptr      <= '0;
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_s1_vld   <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == LAST_ADDR) begin
                    r_clearing <= 1'b0;
                end
            end
            if (w_tick) begin
                r_prev_rst <= i_sample.reset_mv;
                r_prev_clk <= i_sample.clock_mv;
                if (w_clk_edge && w_steps != '0) begin
                    r_ptr <= w_pnext;
                end else if (w_rst_edge) begin
                    r_ptr <= ARMED_POINTER;
                end
            end
            if (w_acc) begin
                r_s1_vld <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1 <= n_s1;
        end
    end

    // stage 2: gate update and output register
    always_comb begin
        case (r_s1.act)
            ACT_SET: n_gate = r_s1.vec;
            ACT_PAT: n_gate = voice_gate(r_rdata, r_s1.mirror);
            default: n_gate = r_gate;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_s1_adv) begin
                r_gate    <= n_gate;
                r_out_vld <= 1'b1;
            end else if (o_gates.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_gate <= n_gate;
        end
    end

    assign o_gates.valid           = r_out_vld;
    assign o_gates.kick_gate       = r_out_gate[0];
    assign o_gates.snare_gate      = r_out_gate[1];
    assign o_gates.closed_hat_gate = r_out_gate[2];
    assign o_gates.open_hat_gate   = r_out_gate[3];

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the drum trigger step sequencer: directed and random beats.
module tb_top;
    import dtss_pkg::*;

    localparam int DEPTH       = 256;
    localparam int STEP_LIMIT  = 99;
    localparam int ITEM_TARGET = 650;
    localparam int MV_MIN      = -16384;
    localparam int MV_MAX      = 16383;

    typedef struct {
        logic               op;
        t_mv                reset_lvl;
        t_mv                clock_lvl;
        logic [STEPS_W-1:0] steps;
        t_mv                variation;
        logic [PICK_W-1:0]  pick;
        logic [INDEX_W-1:0] index;
        t_voice             value;
        bit                 hold_for_drain;
    } t_sample_beat;

    logic i_clk;
    logic i_rst_n;

    dtss_in_if  sample_if ();
    dtss_out_if gates_if ();

    drum_trigger_step_sequencer #(
        .PATTERN_DEPTH(DEPTH),
        .MAX_STEPS    (STEP_LIMIT)
    ) dut (
        .i_clk,
        .i_rst_n,
        .i_sample(sample_if),
        .o_gates (gates_if)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // sequencer state as the block should hold it
    t_voice voices [DEPTH];
    int     last_reset_lvl = 0;
    int     last_clock_lvl = 0;
    t_ptr   step_ptr       = '0;
    t_gates gate_state     = '0;

    t_sample_beat pending [$];
    t_gates       gates_due [$];
    t_sample_beat on_bus;
    bit           beat_live  = 1'b0;
    int           lead_gap   = 0;
    int           hold_off   = 0;
    int           calm_left [2] = '{0, 0};
    int           mismatches = 0;
    t_gates       want_gates;

    function automatic t_gates gate_for(input t_voice v, input bit mirrored);
        if (v < 1 || v > 4)
            return '0;
        return mirrored ? t_gates'(1) << (4 - v) : t_gates'(1) << (v - 1);
    endfunction

    function automatic t_gates advance_sequencer(input t_sample_beat b);
        int     rst_lvl;
        int     clk_lvl;
        int     var_lvl;
        int     steps;
        int     pos;
        int     offset;
        int     bound;
        t_ptr   bumped;
        t_voice voice;
        if (b.op == OP_WRITE) begin
            voices[b.index] = b.value;
        end else begin
            rst_lvl = b.reset_lvl;
            clk_lvl = b.clock_lvl;
            var_lvl = b.variation;
            steps   = b.steps;
            if (steps > STEP_LIMIT)
                steps = STEP_LIMIT;
            if (last_reset_lvl <= 0 && rst_lvl > LVL_HIGH)
                step_ptr = ARMED_POINTER;
            last_reset_lvl = rst_lvl;
            if (last_clock_lvl <= 0 && clk_lvl > LVL_HIGH) begin
                if (steps == 0) begin
                    gate_state = t_gates'(1) << b.pick;
                end else begin
                    bumped = step_ptr + 8'd1;
                    pos = bumped;
                    if (pos >= steps)
                        pos = 0;
                    step_ptr = t_ptr'(pos);
                    voice = voices[pos];
                    if (var_lvl >= VAR_7000) begin
                        gate_state = t_gates'(1) << b.pick;
                    end else if (var_lvl >= VAR_6000) begin
                        gate_state = gate_for(voice, 1'b1);
                    end else if (var_lvl >= VAR_5000) begin
                        gate_state = '0;
                    end else if (var_lvl >= VAR_4000) begin
                        gate_state = 4'b1000;
                    end else if (var_lvl >= VAR_3000) begin
                        gate_state = 4'b0100;
                    end else if (var_lvl >= VAR_2000) begin
                        gate_state = 4'b0010;
                    end else if (var_lvl >= VAR_1000) begin
                        gate_state = 4'b0001;
                    end else if (var_lvl < 0) begin
                        // look-ahead: offset in hundreds of mV, kept inside the store
                        offset = (-var_lvl) / 100;
                        bound  = DEPTH - 1 - steps;
                        if (bound < 0)
                            bound = 0;
                        if (offset > bound)
                            offset = bound;
                        gate_state = gate_for(voices[(pos + offset) % DEPTH], 1'b0);
                    end else begin
                        gate_state = gate_for(voice, 1'b0);
                    end
                end
            end else if (last_clock_lvl > 0 && clk_lvl <= LVL_HIGH) begin
                gate_state = '0;
            end
            last_clock_lvl = clk_lvl;
        end
        return gate_state;
    endfunction

    function automatic int level(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo, 0));
    endfunction

    // mostly short gaps, a few long ones, and now and then a stretch with none
    function automatic int pick_gap(input int side);
        int roll;
        if (calm_left[side] > 0) begin
            calm_left[side]--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2)
            calm_left[side] = $urandom_range(20, 80);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int variation_level();
        int bucket;
        bucket = $urandom_range(0, 9);
        if (bucket == 0)
            return level(0, 999);
        if (bucket <= 6)
            return level(bucket * 1000, bucket * 1000 + 999);
        if (bucket == 7)
            return level(7000, MV_MAX);
        if (bucket == 8)
            return level(MV_MIN, -1);
        return level(-1500, -1);
    endfunction

    function automatic t_sample_beat random_beat();
        t_sample_beat b;
        b.op             = 1'($urandom);
        b.reset_lvl      = t_mv'($urandom);
        b.clock_lvl      = t_mv'($urandom);
        b.steps          = 7'($urandom);
        b.variation      = t_mv'($urandom);
        b.pick           = 2'($urandom);
        b.index          = 8'($urandom);
        b.value          = 3'($urandom);
        b.hold_for_drain = 1'b0;
        return b;
    endfunction

    task automatic add_tick(input int rst, input int clk, input int steps, input int vari,
                            input int pick);
        t_sample_beat b;
        b           = random_beat();
        b.op        = OP_TICK;
        b.reset_lvl = t_mv'(rst);
        b.clock_lvl = t_mv'(clk);
        b.steps     = 7'(steps);
        b.variation = t_mv'(vari);
        b.pick      = 2'(pick);
        pending.push_back(b);
    endtask

    task automatic add_write(input int idx, input int val);
        t_sample_beat b;
        b       = random_beat();
        b.op    = OP_WRITE;
        b.index = 8'(idx);
        b.value = 3'(val);
        pending.push_back(b);
    endtask

    // one musical phrase: optional pattern edits, optional reset pulse, then clock cycles
    task automatic add_phrase();
        int roll;
        int steps;
        int hi_idx;
        roll = $urandom_range(0, 9);
        if (roll < 7)
            steps = level(1, 16);
        else if (roll == 7)
            steps = 0;
        else if (roll == 8)
            steps = level(17, 99);
        else
            steps = level(100, 127);
        hi_idx = steps + 3;
        if ($urandom_range(0, 9) < 3) begin
            repeat ($urandom_range(1, 6)) begin
                add_write(($urandom_range(0, 3) == 0) ? level(0, 255) : level(0, hi_idx),
                          ($urandom_range(0, 4) == 0) ? level(0, 7) : level(1, 4));
            end
        end
        if ($urandom_range(0, 3) == 0)
            add_tick(level(2001, MV_MAX), level(MV_MIN, 0), steps, variation_level(),
                     level(0, 3));
        repeat ($urandom_range(2, 12)) begin
            add_tick(level(-12000, 0), level(2001, MV_MAX), steps, variation_level(),
                     level(0, 3));
            // a low level above 0 V hides the next rising level
            add_tick(level(-12000, 0),
                     ($urandom_range(0, 9) == 0) ? level(1, 2000) : level(MV_MIN, 0),
                     steps, variation_level(), level(0, 3));
            if ($urandom_range(0, 19) == 0)
                pending.push_back(random_beat());
        end
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    // source side: one beat at a time from the pending queue
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            sample_if.valid <= 1'b0;
        end else if (!beat_live) begin
            if (lead_gap > 0) begin
                lead_gap--;
                sample_if.valid <= 1'b0;
            end else if (pending.size() != 0 &&
                         !(pending[0].hold_for_drain && gates_due.size() != 0)) begin
                on_bus    = pending.pop_front();
                beat_live = 1'b1;
                sample_if.operation     <= on_bus.op;
                sample_if.reset_mv      <= on_bus.reset_lvl;
                sample_if.clock_mv      <= on_bus.clock_lvl;
                sample_if.step_count    <= on_bus.steps;
                sample_if.variation_mv  <= on_bus.variation;
                sample_if.random_pick   <= on_bus.pick;
                sample_if.pattern_index <= on_bus.index;
                sample_if.pattern_value <= on_bus.value;
                sample_if.valid         <= 1'b1;
            end else begin
                sample_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && sample_if.valid && sample_if.ready) begin
            gates_due.push_back(advance_sequencer(on_bus));
            beat_live = 1'b0;
            lead_gap  = pick_gap(0);
        end
    end

    // sink side: random back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            gates_if.ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off--;
            gates_if.ready <= 1'b0;
        end else begin
            gates_if.ready <= 1'b1;
            hold_off = pick_gap(1);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && gates_if.valid && gates_if.ready) begin
            if (gates_due.size() == 0) begin
                report_mismatch($sformatf("gate beat %b%b%b%b with nothing expected",
                    gates_if.open_hat_gate, gates_if.closed_hat_gate,
                    gates_if.snare_gate, gates_if.kick_gate));
            end else begin
                want_gates = gates_due.pop_front();
                if (gates_if.kick_gate !== want_gates[0])
                    report_mismatch($sformatf("kick gate %b, expected %b",
                        gates_if.kick_gate, want_gates[0]));
                if (gates_if.snare_gate !== want_gates[1])
                    report_mismatch($sformatf("snare gate %b, expected %b",
                        gates_if.snare_gate, want_gates[1]));
                if (gates_if.closed_hat_gate !== want_gates[2])
                    report_mismatch($sformatf("closed hat gate %b, expected %b",
                        gates_if.closed_hat_gate, want_gates[2]));
                if (gates_if.open_hat_gate !== want_gates[3])
                    report_mismatch($sformatf("open hat gate %b, expected %b",
                        gates_if.open_hat_gate, want_gates[3]));
            end
        end
    end

    initial begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int directed_n;
        int k;
        i_rst_n                 = 1'b0;
        sample_if.valid         = 1'b0;
        sample_if.operation     = OP_TICK;
        sample_if.reset_mv      = '0;
        sample_if.clock_mv      = '0;
        sample_if.step_count    = '0;
        sample_if.variation_mv  = '0;
        sample_if.random_pick   = '0;
        sample_if.pattern_index = '0;
        sample_if.pattern_value = '0;
        gates_if.ready          = 1'b0;
        foreach (voices[i])
            voices[i] = '0;

        add_write(0, 1);
        add_write(1, 2);
        add_write(3, 7);
        add_write(255, 4);
        add_tick(MV_MAX, MV_MIN, 4, 0, 0);   // reset edge arms the pointer
        add_tick(0, 2001, 4, 0, 0);          // lands on step 0: pattern kick
        add_tick(0, 2000, 4, 0, 0);          // fall right at the threshold
        add_tick(0, MV_MAX, 4, 1000, 0);     // previous level above 0 V: no step
        add_tick(0, -1, 4, 0, 0);
        add_tick(0, MV_MAX, 4, 6999, 1);     // step 1, snare mirrored to closed hat
        add_tick(MV_MIN, MV_MIN, 4, 0, 0);
        add_tick(0, 5000, 4, -100, 0);       // look-ahead hits a value with no voice
        add_tick(0, 0, 4, 0, 0);
        add_tick(0, 3000, 4, 1000, 0);       // forced kick
        add_tick(0, -5000, 4, 0, 0);
        add_tick(0, 4000, 4, 2999, 0);       // pointer wraps, forced snare
        add_tick(0, 0, 4, 0, 0);
        add_tick(0, 4000, 4, 4999, 0);       // forced open hat
        add_tick(0, 0, 4, 0, 0);
        add_tick(0, 4000, 4, 5000, 3);       // mute
        add_tick(0, 0, 4, 0, 0);
        add_tick(0, 4000, 4, MV_MAX, 3);     // random voice
        add_tick(0, 0, 0, 0, 0);
        add_tick(0, 4000, 0, 0, 2);          // no steps: random voice, pointer held
        add_tick(0, 0, 127, 0, 0);
        add_tick(0, 4000, 127, MV_MIN, 0);   // step count saturates, offset clamps
        directed_n = pending.size();

        while (pending.size() < ITEM_TARGET)
            add_phrase();
        pending[directed_n].hold_for_drain = 1'b1;
        for (k = directed_n + 150; k < pending.size(); k += 200)
            pending[k].hold_for_drain = 1'b1;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending.size() != 0 || beat_live || gates_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

/* files.f */
rtl/core/dtss_pkg.sv
rtl/core/dtss_in_if.sv
rtl/core/dtss_out_if.sv
rtl/core/drum_trigger_step_sequencer.sv
verif/tb_top.sv
